FILE: rtl/slpc_pkg.sv
// ----------------------------------------------------------------------------
// Status LED pattern controller package
// Shared mode codes, phase codes, register indexes and state types.
// ----------------------------------------------------------------------------
package slpc_pkg;

   localparam int unsigned CountWidth = 8;

   typedef logic [CountWidth-1:0] count_type;

   // Transaction kinds on the request channel.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET  = 1'b1;

   typedef enum logic [2:0] {
      MODE_INIT   = 3'd0,
      MODE_ON     = 3'd1,
      MODE_OFF    = 3'd2,
      MODE_QUICK  = 3'd3,
      MODE_NORMAL = 3'd4,
      MODE_SLOW   = 3'd5,
      MODE_ONCE   = 3'd6,
      MODE_NONE   = 3'd7
   } mode_type;

   // Phases of the light-and-hold sequences (init and blink-once).
   typedef enum logic [1:0] {
      HOLD_IDLE  = 2'd0,
      HOLD_START = 2'd1,
      HOLD_WAIT  = 2'd2
   } hold_phase_type;

   // Phase of the single-shot on and off modes.
   localparam logic LEVEL_IDLE  = 1'b0;
   localparam logic LEVEL_APPLY = 1'b1;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_INIT_HOLD     = 3'd0,
      CSR_QUICK_RELOAD  = 3'd1,
      CSR_NORMAL_RELOAD = 3'd2,
      CSR_SLOW_RELOAD   = 3'd3,
      CSR_ONCE_HOLD     = 3'd4
   } csr_index_type;

   // Configuration register reset values.
   localparam count_type INIT_HOLD_RESET     = 8'd10;
   localparam count_type QUICK_RELOAD_RESET  = 8'd2;
   localparam count_type NORMAL_RELOAD_RESET = 8'd6;
   localparam count_type SLOW_RELOAD_RESET   = 8'd9;
   localparam count_type ONCE_HOLD_RESET     = 8'd5;

   typedef struct packed {
      count_type init_hold;
      count_type quick_reload;
      count_type normal_reload;
      count_type slow_reload;
      count_type once_hold;
   } cfg_type;

   typedef struct packed {
      mode_type       mode;
      logic           pending;
      logic           led;
      hold_phase_type init_phase;
      count_type      init_count;
      logic           on_phase;
      logic           off_phase;
      count_type      quick_count;
      count_type      normal_count;
      count_type      slow_count;
      hold_phase_type once_phase;
      count_type      once_count;
   } state_type;

   localparam cfg_type CFG_RESET = '{
      init_hold:     INIT_HOLD_RESET,
      quick_reload:  QUICK_RELOAD_RESET,
      normal_reload: NORMAL_RELOAD_RESET,
      slow_reload:   SLOW_RELOAD_RESET,
      once_hold:     ONCE_HOLD_RESET
   };

   localparam state_type STATE_RESET = '{
      mode:         MODE_INIT,
      pending:      1'b0,
      led:          1'b0,
      init_phase:   HOLD_IDLE,
      init_count:   '0,
      on_phase:     LEVEL_IDLE,
      off_phase:    LEVEL_IDLE,
      quick_count:  QUICK_RELOAD_RESET,
      normal_count: NORMAL_RELOAD_RESET,
      slow_count:   SLOW_RELOAD_RESET,
      once_phase:   HOLD_IDLE,
      once_count:   '0
   };

endpackage

FILE: rtl/slpc_step.sv
// ----------------------------------------------------------------------------
// Status LED pattern step logic
// Next-state function for one request transaction: a mode set or a tick.
// ----------------------------------------------------------------------------
module slpc_step (
   input  slpc_pkg::state_type state,
   input  slpc_pkg::cfg_type   cfg,
   input  logic                op,
   input  logic [2:0]          new_mode,
   output slpc_pkg::state_type next_state
);
   import slpc_pkg::*;

   typedef struct packed {
      hold_phase_type phase;
      count_type      count;
      logic           led;
      logic           pending;
   } hold_type;

   typedef struct packed {
      count_type count;
      logic      led;
   } blink_type;

   // Light, hold for a count, then settle at the final level.
   function automatic hold_type hold_step(input hold_phase_type phase,
                                          input count_type count,
                                          input count_type hold,
                                          input logic led,
                                          input logic pending,
                                          input logic final_level);
      hold_type r;
      r.phase   = pending ? HOLD_START : phase;
      r.count   = count;
      r.led     = led;
      r.pending = 1'b0;
      case (r.phase)
         HOLD_START: begin
            r.phase = HOLD_WAIT;
            r.count = hold;
            r.led   = 1'b1;
         end
         HOLD_WAIT: begin
            if (count == '0) begin
               r.phase = HOLD_IDLE;
               r.led   = final_level;
            end else begin
               r.count = count - 1'b1;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Free-running countdown that toggles the LED when it expires.
   function automatic blink_type blink_step(input count_type count,
                                            input count_type reload,
                                            input logic led);
      blink_type r;
      if (count == '0) begin
         r.count = reload;
         r.led   = ~led;
      end else begin
         r.count = count - 1'b1;
         r.led   = led;
      end
      return r;
   endfunction

   hold_type  hold_init;
   hold_type  hold_once;
   blink_type blink_quick;
   blink_type blink_normal;
   blink_type blink_slow;

   always_comb begin
      hold_init    = hold_step(state.init_phase, state.init_count, cfg.init_hold,
                               state.led, state.pending, 1'b1);
      hold_once    = hold_step(state.once_phase, state.once_count, cfg.once_hold,
                               state.led, state.pending, 1'b0);
      blink_quick  = blink_step(state.quick_count, cfg.quick_reload, state.led);
      blink_normal = blink_step(state.normal_count, cfg.normal_reload, state.led);
      blink_slow   = blink_step(state.slow_count, cfg.slow_reload, state.led);

      next_state = state;
      if (op == OP_SET) begin
         next_state.pending = 1'b1;
         next_state.mode    = mode_type'(new_mode);
      end else begin
         unique case (state.mode)
            MODE_INIT: begin
               next_state.init_phase = hold_init.phase;
               next_state.init_count = hold_init.count;
               next_state.led        = hold_init.led;
               next_state.pending    = hold_init.pending;
            end
            MODE_ON, MODE_OFF: begin
               // A pending set arms the single shot; it fires on this tick.
               if (state.pending) begin
                  next_state.pending = 1'b0;
                  next_state.led     = (state.mode == MODE_ON);
               end else if (state.mode == MODE_ON && state.on_phase == LEVEL_APPLY) begin
                  next_state.led = 1'b1;
               end else if (state.mode == MODE_OFF && state.off_phase == LEVEL_APPLY) begin
                  next_state.led = 1'b0;
               end
               if (state.mode == MODE_ON) begin
                  next_state.on_phase = LEVEL_IDLE;
               end else begin
                  next_state.off_phase = LEVEL_IDLE;
               end
            end
            MODE_QUICK: begin
               next_state.quick_count = blink_quick.count;
               next_state.led         = blink_quick.led;
            end
            MODE_NORMAL: begin
               next_state.normal_count = blink_normal.count;
               next_state.led          = blink_normal.led;
            end
            MODE_SLOW: begin
               next_state.slow_count = blink_slow.count;
               next_state.led        = blink_slow.led;
            end
            MODE_ONCE: begin
               next_state.once_phase = hold_once.phase;
               next_state.once_count = hold_once.count;
               next_state.led        = hold_once.led;
               next_state.pending    = hold_once.pending;
            end
            default: begin
               // No mode selected: the tick changes nothing.
            end
         endcase
      end
   end

endmodule

FILE: rtl/status_led_pattern_controller.sv
// ----------------------------------------------------------------------------
// Status LED pattern controller
// Drives a status LED from timer ticks and mode-set transactions.
// ----------------------------------------------------------------------------
// Every request transaction returns exactly one response transaction that
// carries the LED level after it. The controller takes one request per clock
// unless a stall on the response side holds it back: the whole mode update for
// a transaction is a single pass of next-state logic between the state registers
// and the response register, so a taken request has its response on the next cycle.
// The response register parts the two channels; req_ready is high whenever
// that register is empty or its transaction is being taken in the same cycle,
// so a stall on the response side holds back at most one request.
module status_led_pattern_controller (
   input  logic       clock,
   input  logic       reset,
   // Request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic [2:0] req_new_mode,
   // Response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_led_lit,
   // Configuration write channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import slpc_pkg::*;

   // Controller state: the active mode, the pending flag, the LED level and
   // the private phases and counters of each mode. Counters of modes that
   // are not active keep their values across mode switches.
   state_type state_ff;
   state_type state_in;
   state_type state_step;

   // Configuration registers; the user must write them only while the block is idle (not enforced here).
   cfg_type   cfg_ff;
   cfg_type   cfg_in;

   // Response register.
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_led_ff;
   logic      rsp_led_in;

   logic      req_take;

   // A request is taken when the response register has room for its result.
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_take  = req_valid & req_ready;

   // Configuration writes never stall.
   assign csr_ready = 1'b1;

   slpc_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .op         (req_op),
      .new_mode   (req_new_mode),
      .next_state (state_step)
   );

   always_comb begin
      state_in     = req_take ? state_step : state_ff;
      rsp_valid_in = req_take | (rsp_valid_ff & ~rsp_ready);
      rsp_led_in   = req_take ? state_step.led : rsp_led_ff;
   end

   // Register decode: writes to indexes beyond the register list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_INIT_HOLD:     cfg_in.init_hold     = csr_wdata;
            CSR_QUICK_RELOAD:  cfg_in.quick_reload  = csr_wdata;
            CSR_NORMAL_RELOAD: cfg_in.normal_reload = csr_wdata;
            CSR_SLOW_RELOAD:   cfg_in.slow_reload   = csr_wdata;
            CSR_ONCE_HOLD:     cfg_in.once_hold     = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The response level is payload and needs no reset.
   always_ff @(posedge clock) begin
      rsp_led_ff <= rsp_led_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_led_lit = rsp_led_ff;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status LED pattern controller testbench
// Drives tick and mode-set transactions through the request channel under
// several register settings, predicts the LED level of every response with a
// model of the mode sequencer, and compares each response in order.
// ----------------------------------------------------------------------------
module testbench;

   import slpc_pkg::*;

   // Slots of the per-mode state arrays in the predictor.
   localparam int SLOT_INIT   = 0;
   localparam int SLOT_ONCE   = 1;
   localparam int SLOT_ON     = 0;
   localparam int SLOT_OFF    = 1;
   localparam int SLOT_QUICK  = 0;
   localparam int SLOT_NORMAL = 1;
   localparam int SLOT_SLOW   = 2;

   localparam int unsigned PHASE_ITEMS = 300;
   localparam int unsigned HOLD_OFF_CYCLES = 400;

   // One row of the directed table. When known is set, led is the response
   // that the row must produce; otherwise the predictor supplies it.
   typedef struct packed {
      logic     op;
      mode_type mode;
      logic     known;
      logic     led;
   } step_row_type;

   logic       clock;
   logic       reset        = 1'b1;
   logic       req_valid    = 1'b0;
   logic       req_ready;
   logic       req_op       = OP_TICK;
   logic [2:0] req_new_mode = MODE_INIT;
   logic       rsp_valid;
   logic       rsp_ready    = 1'b0;
   logic       rsp_led_lit;
   logic       csr_valid    = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index    = CSR_INIT_HOLD;
   logic [7:0] csr_wdata    = 8'd0;

   // Sideband that travels with the request payload: a typed-in expectation.
   logic row_known = 1'b0;
   logic row_led   = 1'b0;

   // Stimulus-to-receiver controls.
   bit hold_off_armed = 1'b0;
   bit quiet_tail     = 1'b0;

   int unsigned mismatch_count = 0;
   logic        led_expect_q [$];

   // Predictor state: configuration shadow and the mode sequencer.
   cfg_type        led_cfg;
   mode_type       led_mode;
   logic           led_pending;
   logic           led_now;
   hold_phase_type hold_phase [2];
   logic [7:0]     hold_count [2];
   logic           level_phase [2];
   logic [7:0]     blink_count [3];

   step_row_type directed [0:24];
   cfg_type      plans [0:5];

   status_led_pattern_controller dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_new_mode (req_new_mode),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_led_lit  (rsp_led_lit),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   function automatic void reset_predictor();
      led_cfg.init_hold     = 8'd10;
      led_cfg.quick_reload  = 8'd2;
      led_cfg.normal_reload = 8'd6;
      led_cfg.slow_reload   = 8'd9;
      led_cfg.once_hold     = 8'd5;
      led_mode    = MODE_INIT;
      led_pending = 1'b0;
      led_now     = 1'b0;
      foreach (hold_phase[k]) begin
         hold_phase[k] = HOLD_IDLE;
         hold_count[k] = 8'd0;
      end
      foreach (level_phase[k]) level_phase[k] = LEVEL_IDLE;
      blink_count[SLOT_QUICK]  = led_cfg.quick_reload;
      blink_count[SLOT_NORMAL] = led_cfg.normal_reload;
      blink_count[SLOT_SLOW]   = led_cfg.slow_reload;
   endfunction

   // Light, hold for the given count, then settle at the final level. The
   // hold ends on the tick that finds the count already at zero.
   function automatic void hold_step(input int slot, input logic [7:0] hold,
                                     input logic final_level);
      if (led_pending) begin
         led_pending = 1'b0;
         hold_phase[slot] = HOLD_START;
      end
      if (hold_phase[slot] == HOLD_START) begin
         hold_phase[slot] = HOLD_WAIT;
         hold_count[slot] = hold;
         led_now = 1'b1;
      end else if (hold_phase[slot] == HOLD_WAIT) begin
         if (hold_count[slot] == 8'd0) begin
            hold_phase[slot] = HOLD_IDLE;
            led_now = final_level;
         end else begin
            hold_count[slot] = hold_count[slot] - 8'd1;
         end
      end
   endfunction

   // Apply a fixed level once after a mode set.
   function automatic void level_step(input int slot, input logic level);
      if (led_pending) begin
         led_pending = 1'b0;
         level_phase[slot] = LEVEL_APPLY;
      end
      if (level_phase[slot] == LEVEL_APPLY) begin
         level_phase[slot] = LEVEL_IDLE;
         led_now = level;
      end
   endfunction

   // Blink countdowns never touch the pending flag and keep their count
   // across mode switches; a new reload value is only picked up on expiry.
   function automatic void blink_step(input int slot, input logic [7:0] reload);
      if (blink_count[slot] == 8'd0) begin
         blink_count[slot] = reload;
         led_now = ~led_now;
      end else begin
         blink_count[slot] = blink_count[slot] - 8'd1;
      end
   endfunction

   function automatic logic predict_led(input logic op, input mode_type mode);
      if (op == OP_SET) begin
         led_pending = 1'b1;
         led_mode = mode;
      end else begin
         case (led_mode)
            MODE_INIT:   hold_step(SLOT_INIT, led_cfg.init_hold, 1'b1);
            MODE_ON:     level_step(SLOT_ON, 1'b1);
            MODE_OFF:    level_step(SLOT_OFF, 1'b0);
            MODE_QUICK:  blink_step(SLOT_QUICK, led_cfg.quick_reload);
            MODE_NORMAL: blink_step(SLOT_NORMAL, led_cfg.normal_reload);
            MODE_SLOW:   blink_step(SLOT_SLOW, led_cfg.slow_reload);
            MODE_ONCE:   hold_step(SLOT_ONCE, led_cfg.once_hold, 1'b0);
            default: ;
         endcase
      end
      return led_now;
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: every accepted request pushes one expected LED level, every
   // accepted response is compared against the oldest one. Sampling happens
   // at the clock edge, before any of this edge's assignments take effect.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      logic led_guess;
      if (!reset) begin
         if (req_valid && req_ready) begin
            led_guess = predict_led(req_op, mode_type'(req_new_mode));
            led_expect_q.push_back(row_known ? row_led : led_guess);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INIT_HOLD:     led_cfg.init_hold     = csr_wdata;
               CSR_QUICK_RELOAD:  led_cfg.quick_reload  = csr_wdata;
               CSR_NORMAL_RELOAD: led_cfg.normal_reload = csr_wdata;
               CSR_SLOW_RELOAD:   led_cfg.slow_reload   = csr_wdata;
               CSR_ONCE_HOLD:     led_cfg.once_hold     = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (led_expect_q.size() == 0) begin
               $error("led_lit: no transaction expected, got %0b", rsp_led_lit);
               mismatch_count++;
            end else begin
               led_guess = led_expect_q.pop_front();
               if (rsp_led_lit !== led_guess) begin
                  $error("led_lit: expected %0b, got %0b", led_guess, rsp_led_lit);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response side: random ready bursts and stalls, one long hold-off on
   // request so that the controller backs up into the request channel, and
   // a steady ready during the quiet tail of the run.
   // ------------------------------------------------------------------------
   initial begin : response_sink
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (quiet_tail) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side helpers. Valid stays high from one transaction to the next;
   // it is only lowered by a gap or a drain, so it never sees two
   // nonblocking assignments in the same time step.
   // ------------------------------------------------------------------------
   task automatic send_request(input logic op, input mode_type mode,
                               input logic known, input logic led);
      req_op       <= op;
      req_new_mode <= mode;
      row_known    <= known;
      row_led      <= led;
      req_valid    <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic sender_gap();
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Stop offering requests and wait until every response has come back.
   // The first edge lets the monitor record the last accepted transaction.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (led_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [7:0] value);
      csr_index <= index;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes every register, then one index past the end that must be ignored.
   task automatic load_settings(input cfg_type plan);
      write_register(CSR_INIT_HOLD, plan.init_hold);
      write_register(CSR_QUICK_RELOAD, plan.quick_reload);
      write_register(CSR_NORMAL_RELOAD, plan.normal_reload);
      write_register(CSR_SLOW_RELOAD, plan.slow_reload);
      write_register(CSR_ONCE_HOLD, plan.once_hold);
      write_register(3'($urandom_range(7, 5)), 8'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic cfg_type random_settings(input int unsigned top);
      cfg_type plan;
      plan.init_hold     = 8'($urandom_range(0, top));
      plan.quick_reload  = 8'($urandom_range(0, top));
      plan.normal_reload = 8'($urandom_range(0, top));
      plan.slow_reload   = 8'($urandom_range(0, top));
      plan.once_hold     = 8'($urandom_range(0, top));
      return plan;
   endfunction

   // Mostly well-formed traffic: a mode set followed by a run of ticks, with
   // the odd long run so that the longest holds and reloads expire. The rest
   // is single transactions of random kind.
   task automatic run_random_phase(input int unsigned count, input bit with_hold_off);
      int unsigned issued;
      int unsigned run_len;
      issued = 0;
      while (issued < count) begin
         if (with_hold_off && issued == 0) hold_off_armed = 1'b1;
         if ($urandom_range(0, 9) < 8) begin
            send_request(OP_SET, mode_type'($urandom_range(0, 7)), 1'b0, 1'b0);
            sender_gap();
            issued++;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
            repeat (run_len) begin
               send_request(OP_TICK, mode_type'($urandom_range(0, 7)), 1'b0, 1'b0);
               sender_gap();
               issued++;
            end
         end else begin
            send_request($urandom_range(0, 1) == 1, mode_type'($urandom_range(0, 7)),
                         1'b0, 1'b0);
            sender_gap();
            issued++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      // Directed walk with the reset register values. Ticks carry arbitrary
      // mode bits, which the controller must ignore.
      directed = '{
         '{OP_TICK, MODE_ONCE,   1'b1, 1'b0},  // init mode with nothing pending
         '{OP_SET,  MODE_INIT,   1'b1, 1'b0},  // mode set leaves the LED alone
         '{OP_TICK, MODE_NONE,   1'b1, 1'b1},  // init lights the LED
         '{OP_TICK, MODE_ON,     1'b0, 1'b0},
         '{OP_SET,  MODE_ON,     1'b0, 1'b0},
         '{OP_TICK, MODE_OFF,    1'b1, 1'b1},
         '{OP_SET,  MODE_OFF,    1'b1, 1'b1},
         '{OP_TICK, MODE_QUICK,  1'b1, 1'b0},  // off applied once
         '{OP_TICK, MODE_INIT,   1'b1, 1'b0},
         '{OP_SET,  MODE_NONE,   1'b1, 1'b0},
         '{OP_TICK, MODE_SLOW,   1'b1, 1'b0},  // no mode: nothing happens
         '{OP_SET,  MODE_QUICK,  1'b0, 1'b0},
         '{OP_TICK, MODE_INIT,   1'b0, 1'b0},
         '{OP_TICK, MODE_INIT,   1'b0, 1'b0},
         '{OP_TICK, MODE_INIT,   1'b0, 1'b0},
         '{OP_TICK, MODE_INIT,   1'b0, 1'b0},
         '{OP_SET,  MODE_NORMAL, 1'b0, 1'b0},
         '{OP_TICK, MODE_NONE,   1'b0, 1'b0},
         '{OP_SET,  MODE_SLOW,   1'b0, 1'b0},
         '{OP_TICK, MODE_NONE,   1'b0, 1'b0},
         '{OP_SET,  MODE_ONCE,   1'b0, 1'b0},
         '{OP_TICK, MODE_NONE,   1'b1, 1'b1},  // blink-once lights first
         '{OP_TICK, MODE_NONE,   1'b0, 1'b0},
         '{OP_SET,  MODE_INIT,   1'b0, 1'b0},
         '{OP_TICK, MODE_NONE,   1'b1, 1'b1}   // init relit after a new set
      };

      // Register plans: both extremes, random spreads, and back to reset.
      plans[0] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      plans[1] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      plans[2] = random_settings(255);
      plans[3] = random_settings(3);
      plans[4] = random_settings(20);
      plans[5] = '{8'd10, 8'd2, 8'd6, 8'd9, 8'd5};

      reset_predictor();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_request(directed[i].op, directed[i].mode, directed[i].known, directed[i].led);

      // Each phase starts from a drained controller so the register writes
      // land while it is idle; the running countdowns carry over.
      foreach (plans[p]) begin
         drain();
         load_settings(plans[p]);
         if (p == 5) quiet_tail = 1'b1;
         run_random_phase(PHASE_ITEMS, p == 2);
      end

      drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && led_expect_q.size() == 0) begin
         $display("status_led_pattern_controller test passed");
      end else begin
         $display("status_led_pattern_controller test failed");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin : watchdog
      #10_000_000;
      $display("status_led_pattern_controller test failed");
      $finish;
   end

endmodule

FILE: status_led_pattern_controller.f
rtl/slpc_pkg.sv
rtl/slpc_step.sv
rtl/status_led_pattern_controller.sv
test/testbench.sv
